// ===== hw/rtl/fcpq_pkg.sv =====
// shared types and constants of the four-class priority queue
package fcpq_pkg;

    localparam int NUM_CLASSES     = 4;
    localparam int CLASS_W         = 2;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_W           = 16;
    localparam int AGE_W           = 8;

    localparam logic [AGE_W-1:0] SENIOR_AGE_RESET = 8'd60;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_DROPPED  = 2'd3
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
        logic             aggravating;
    } entry_t;

endpackage

// ===== hw/rtl/fcpq_if.sv =====
// channel interfaces: request, response and configuration write
interface fcpq_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [fcpq_pkg::TAG_W-1:0] tag;
    logic [fcpq_pkg::AGE_W-1:0] age;
    logic                      aggravating;

    modport source (output valid, mode, tag, age, aggravating, input ready);
    modport sink   (input valid, mode, tag, age, aggravating, output ready);
endinterface

interface fcpq_rsp_if;
    logic                        valid;
    logic                        ready;
    fcpq_pkg::status_t           status;
    logic [fcpq_pkg::TAG_W-1:0]   out_tag;
    logic [fcpq_pkg::AGE_W-1:0]   out_age;
    logic                        out_aggravating;
    logic [fcpq_pkg::CLASS_W-1:0] out_class;
    logic                        all_empty;

    modport source (output valid, status, out_tag, out_age, out_aggravating, out_class,
                    all_empty, input ready);
    modport sink   (input valid, status, out_tag, out_age, out_aggravating, out_class,
                    all_empty, output ready);
endinterface

interface fcpq_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [fcpq_pkg::AGE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/four_class_priority_queue_core.sv =====
// four-class strict-priority queue with entries held in one synchronous memory
//
//  channel | dir | payload                                             | accepted when
//  req     | in  | mode, tag, age, aggravating                         | valid && ready
//  rsp     | out | status, out_tag, out_age, out_aggravating,          | valid && ready
//          |     | out_class, all_empty                                |
//  cfg     | in  | data (senior_age)                                   | valid && ready
//
// one item per cycle while rsp is taken; each result passes from the s1 stage registers into the output register
// the entry memory read is done in the accept cycle and registered
// pointers and counts live in flops and update at accept, so no forwarding is needed
// reset clears pointers and counts and sets senior_age to 60; the entry memory is not cleared
// req stalls only when both the read stage and the result stage hold items and rsp is not taken
module four_class_priority_queue_core #(
    parameter int QUEUE_DEPTH = fcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fcpq_req_if.sink     req,
    fcpq_rsp_if.source   rsp,
    fcpq_cfg_if.sink     cfg
);

    localparam int NCLS      = fcpq_pkg::NUM_CLASSES;
    localparam int CLASS_W   = fcpq_pkg::CLASS_W;
    localparam int MEM_DEPTH = NCLS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(QUEUE_DEPTH);

    fcpq_pkg::entry_t mem [MEM_DEPTH];

    logic [fcpq_pkg::AGE_W-1:0] senior_age_reg;
    logic [PTR_W-1:0]           head_reg [NCLS];
    logic [PTR_W-1:0]           head_next [NCLS];
    logic [PTR_W-1:0]           tail_reg [NCLS];
    logic [PTR_W-1:0]           tail_next [NCLS];
    logic [CNT_W-1:0]           cnt_reg [NCLS];
    logic [CNT_W-1:0]           cnt_next [NCLS];

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    fcpq_pkg::status_t          s1_status_reg;
    fcpq_pkg::status_t          s1_status_next;
    logic [CLASS_W-1:0]         s1_class_reg;
    logic [CLASS_W-1:0]         s1_class_next;
    logic                       s1_empty_reg;
    logic                       s1_empty_next;
    fcpq_pkg::entry_t           rd_data_reg;

    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    fcpq_pkg::status_t          rsp_status_reg;
    fcpq_pkg::entry_t           rsp_entry_reg;
    fcpq_pkg::entry_t           rsp_entry_next;
    logic [CLASS_W-1:0]         rsp_class_reg;
    logic                       rsp_empty_reg;

    logic                       accept;
    logic                       advance;
    logic [CLASS_W-1:0]         ins_class;
    logic [CLASS_W-1:0]         pick_class;
    logic                       pick_hit;
    logic                       ins_full;
    logic                       wr_en;
    logic                       rd_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    fcpq_pkg::entry_t           wr_data;
    logic                       any_left;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == LAST_PTR) ? '0 : PTR_W'(p + PTR_W'(1));
        return r;
    endfunction

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign ins_class = {req.aggravating, (req.age >= senior_age_reg)};
    assign ins_full  = (cnt_reg[ins_class] == FULL_CNT);

    // highest non-empty class wins
    always_comb
    begin
        pick_hit   = 1'b1;
        pick_class = '0;
        priority if (cnt_reg[3] != '0)
        begin
            pick_class = 2'd3;
        end
        else if (cnt_reg[2] != '0)
        begin
            pick_class = 2'd2;
        end
        else if (cnt_reg[1] != '0)
        begin
            pick_class = 2'd1;
        end
        else if (cnt_reg[0] != '0)
        begin
            pick_class = 2'd0;
        end
        else
        begin
            pick_hit = 1'b0;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NCLS; c++)
        begin
            head_next[c] = head_reg[c];
            tail_next[c] = tail_reg[c];
            cnt_next[c]  = cnt_reg[c];
        end
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = ADDR_W'(ins_class) * ROW_STRIDE + ADDR_W'(tail_reg[ins_class]);
        rd_addr        = ADDR_W'(pick_class) * ROW_STRIDE + ADDR_W'(head_reg[pick_class]);
        wr_data        = '{tag: req.tag, age: req.age, aggravating: req.aggravating};
        s1_status_next = s1_status_reg;
        s1_class_next  = s1_class_reg;
        if (accept)
        begin
            if (req.mode == fcpq_pkg::MODE_INSERT)
            begin
                s1_class_next = ins_class;
                if (ins_full)
                begin
                    s1_status_next = fcpq_pkg::ST_DROPPED;
                end
                else
                begin
                    s1_status_next       = fcpq_pkg::ST_INSERTED;
                    wr_en                = 1'b1;
                    tail_next[ins_class] = ptr_inc(tail_reg[ins_class]);
                    cnt_next[ins_class]  = CNT_W'(cnt_reg[ins_class] + CNT_W'(1));
                end
            end
            else if (pick_hit)
            begin
                s1_status_next        = fcpq_pkg::ST_REMOVED;
                s1_class_next         = pick_class;
                rd_en                 = 1'b1;
                head_next[pick_class] = ptr_inc(head_reg[pick_class]);
                cnt_next[pick_class]  = CNT_W'(cnt_reg[pick_class] - CNT_W'(1));
            end
            else
            begin
                s1_status_next = fcpq_pkg::ST_EMPTY;
                s1_class_next  = '0;
            end
        end
    end

    always_comb
    begin
        any_left = 1'b0;
        for (int c = 0; c < NCLS; c++)
        begin
            any_left = any_left || (cnt_next[c] != '0);
        end
    end

    assign s1_empty_next = accept ? !any_left : s1_empty_reg;
    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign rsp_valid_next = advance ? s1_valid_reg : rsp_valid_reg;
    assign rsp_entry_next = (s1_status_reg == fcpq_pkg::ST_REMOVED) ? rd_data_reg : '0;

    // entry memory, at most one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            senior_age_reg <= fcpq_pkg::SENIOR_AGE_RESET;
            for (int c = 0; c < NCLS; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                senior_age_reg <= cfg.data;
            end
            for (int c = 0; c < NCLS; c++)
            begin
                head_reg[c] <= head_next[c];
                tail_reg[c] <= tail_next[c];
                cnt_reg[c]  <= cnt_next[c];
            end
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_status_reg <= s1_status_next;
        s1_class_reg  <= s1_class_next;
        s1_empty_reg  <= s1_empty_next;
        if (advance && s1_valid_reg)
        begin
            rsp_status_reg <= s1_status_reg;
            rsp_entry_reg  <= rsp_entry_next;
            rsp_class_reg  <= s1_class_reg;
            rsp_empty_reg  <= s1_empty_reg;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.out_tag         = rsp_entry_reg.tag;
    assign rsp.out_age         = rsp_entry_reg.age;
    assign rsp.out_aggravating = rsp_entry_reg.aggravating;
    assign rsp.out_class       = rsp_class_reg;
    assign rsp.all_empty       = rsp_empty_reg;

endmodule

// ===== hw/rtl/fcpq_checker.sv =====
// port-level checks of the four-class priority queue, bound to the queue core
module fcpq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input fcpq_pkg::status_t            rsp_status,
    input logic [fcpq_pkg::TAG_W-1:0]   rsp_out_tag,
    input logic [fcpq_pkg::CLASS_W-1:0] rsp_out_class,
    input logic                         rsp_all_empty
);

    // stalled item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_tag))
        else $error("stalled item changed");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == fcpq_pkg::ST_EMPTY
        |-> rsp_all_empty && rsp_out_tag == '0 && rsp_out_class == '0)
        else $error("empty remove reported wrong fields");

    a_insert_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == fcpq_pkg::ST_INSERTED || rsp_status == fcpq_pkg::ST_DROPPED)
        |-> !rsp_all_empty)
        else $error("insert or drop reported all queues empty");

    a_drop_no_tag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == fcpq_pkg::ST_DROPPED |-> rsp_out_tag == '0)
        else $error("dropped insert carried a tag");

endmodule

bind four_class_priority_queue_core fcpq_checker u_fcpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_out_tag   (rsp.out_tag),
    .rsp_out_class (rsp.out_class),
    .rsp_all_empty (rsp.all_empty)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the four-class strict-priority queue core
`timescale 1ns / 1ps

module testbench;

    localparam int TAG_W       = fcpq_pkg::TAG_W;
    localparam int AGE_W       = fcpq_pkg::AGE_W;
    localparam int CLASS_W     = fcpq_pkg::CLASS_W;
    localparam int NUM_CLASSES = fcpq_pkg::NUM_CLASSES;
    localparam int DEPTH       = fcpq_pkg::QUEUE_DEPTH_DEF;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 203;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        fcpq_pkg::mode_t  mode;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
        logic             aggravating;
    } request_t;

    typedef struct {
        fcpq_pkg::status_t  status;
        logic [TAG_W-1:0]   tag;
        logic [AGE_W-1:0]   age;
        logic               aggravating;
        logic [CLASS_W-1:0] cls;
        logic               all_empty;
    } answer_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fcpq_req_if req_ch ();
    fcpq_rsp_if rsp_ch ();
    fcpq_cfg_if cfg_ch ();

    four_class_priority_queue_core #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch),
        .cfg  (cfg_ch)
    );

    fcpq_pkg::entry_t slot_mem    [NUM_CLASSES][DEPTH];
    int               class_head  [NUM_CLASSES];
    int               class_tail  [NUM_CLASSES];
    int               class_count [NUM_CLASSES];
    logic [AGE_W-1:0] senior_age;

    request_t requests_to_send[$];
    answer_t  answers_due[$];
    request_t req_cur;
    bit       req_busy = 1'b0;
    bit       req_fire = 1'b0;
    bit       req_calm = 1'b0;
    bit       rsp_fire = 1'b0;
    bit       rsp_calm = 1'b0;
    int       req_gap = 0;
    int       rsp_stall = 0;
    int       rsp_hold_left = 0;
    int       mismatches = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic answer_t apply_request(request_t r);
        answer_t            a;
        logic [CLASS_W-1:0] c;
        int                 k;
        a.status      = fcpq_pkg::ST_INSERTED;
        a.tag         = '0;
        a.age         = '0;
        a.aggravating = 1'b0;
        a.cls         = '0;
        if (r.mode == fcpq_pkg::MODE_INSERT)
        begin
            c     = {r.aggravating, r.age >= senior_age};
            a.cls = c;
            if (class_count[c] >= DEPTH)
                a.status = fcpq_pkg::ST_DROPPED;
            else
            begin
                slot_mem[c][class_tail[c]].tag         = r.tag;
                slot_mem[c][class_tail[c]].age         = r.age;
                slot_mem[c][class_tail[c]].aggravating = r.aggravating;
                class_tail[c]  = (class_tail[c] + 1) % DEPTH;
                class_count[c] = class_count[c] + 1;
            end
        end
        else
        begin
            a.status = fcpq_pkg::ST_EMPTY;
            for (k = NUM_CLASSES - 1; k >= 0; k--)
            begin
                if (a.status == fcpq_pkg::ST_EMPTY && class_count[k] != 0)
                begin
                    a.status      = fcpq_pkg::ST_REMOVED;
                    a.tag         = slot_mem[k][class_head[k]].tag;
                    a.age         = slot_mem[k][class_head[k]].age;
                    a.aggravating = slot_mem[k][class_head[k]].aggravating;
                    a.cls         = k[CLASS_W-1:0];
                    class_head[k]  = (class_head[k] + 1) % DEPTH;
                    class_count[k] = class_count[k] - 1;
                end
            end
        end
        a.all_empty = 1'b1;
        for (k = 0; k < NUM_CLASSES; k++)
            if (class_count[k] != 0)
                a.all_empty = 1'b0;
        return a;
    endfunction

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [AGE_W-1:0] pick_age();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel < 2)
            return senior_age + AGE_W'($urandom_range(0, 2)) - 8'd1;
        else if (sel == 2)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return AGE_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] %s", $time, what);
    endtask

    task automatic add_request(input fcpq_pkg::mode_t m, input logic [TAG_W-1:0] tag,
                               input logic [AGE_W-1:0] age, input logic aggr);
        request_t r;
        r.mode        = m;
        r.tag         = tag;
        r.age         = age;
        r.aggravating = aggr;
        requests_to_send.push_back(r);
    endtask

    task automatic wait_drained();
        while (requests_to_send.size() != 0 || answers_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_senior_age(input logic [AGE_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        senior_age = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_fire)
            begin
                req_fire = 1'b0;
                req_busy = 1'b0;
                req_gap  = draw_wait(req_calm);
            end
            if (!req_busy)
            begin
                if (req_gap != 0)
                begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (requests_to_send.size() != 0)
                begin
                    req_cur = requests_to_send[0];
                    req_busy = 1'b1;
                    req_ch.valid       <= 1'b1;
                    req_ch.mode        <= req_cur.mode;
                    req_ch.tag         <= req_cur.tag;
                    req_ch.age         <= req_cur.age;
                    req_ch.aggravating <= req_cur.aggravating;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            answers_due.push_back(apply_request(req_cur));
            requests_to_send.delete(0);
            req_fire = 1'b1;
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (rsp_hold_left != 0)
            rsp_hold_left <= rsp_hold_left - 1;
    end

    // result ready driver
    always @(negedge clk)
    begin
        if (rsp_fire)
        begin
            rsp_fire  = 1'b0;
            rsp_stall = draw_wait(rsp_calm);
        end
        if (rsp_hold_left != 0)
            rsp_ch.ready <= 1'b0;
        else if (rsp_stall != 0)
        begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        answer_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_fire = 1'b1;
            if (answers_due.size() == 0)
                report_mismatch("result item arrived with none outstanding");
            else
            begin
                want = answers_due.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp_ch.status, want.status));
                if (rsp_ch.out_tag !== want.tag)
                    report_mismatch($sformatf("out_tag %h, want %h",
                                              rsp_ch.out_tag, want.tag));
                if (rsp_ch.out_age !== want.age)
                    report_mismatch($sformatf("out_age %0d, want %0d",
                                              rsp_ch.out_age, want.age));
                if (rsp_ch.out_aggravating !== want.aggravating)
                    report_mismatch($sformatf("out_aggravating %b, want %b",
                                              rsp_ch.out_aggravating, want.aggravating));
                if (rsp_ch.out_class !== want.cls)
                    report_mismatch($sformatf("out_class %0d, want %0d",
                                              rsp_ch.out_class, want.cls));
                if (rsp_ch.all_empty !== want.all_empty)
                    report_mismatch($sformatf("all_empty %b, want %b",
                                              rsp_ch.all_empty, want.all_empty));
            end
        end
    end

    initial
    begin : stimulus
        logic [AGE_W-1:0] phase_age [PHASES];
        fcpq_pkg::mode_t  m;
        int               p;
        int               n;
        int               bias;
        req_ch.valid       = 1'b0;
        req_ch.mode        = fcpq_pkg::MODE_INSERT;
        req_ch.tag         = '0;
        req_ch.age         = '0;
        req_ch.aggravating = 1'b0;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        senior_age         = fcpq_pkg::SENIOR_AGE_RESET;
        for (n = 0; n < NUM_CLASSES; n++)
        begin
            class_head[n]  = 0;
            class_tail[n]  = 0;
            class_count[n] = 0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed items at the reset threshold
        @(posedge clk);
        add_request(fcpq_pkg::MODE_REMOVE, 16'hFFFF, 8'hFF, 1'b1);
        add_request(fcpq_pkg::MODE_INSERT, 16'h5A5A, 8'd0, 1'b0);
        add_request(fcpq_pkg::MODE_INSERT, 16'hA5A5, 8'd60, 1'b0);
        add_request(fcpq_pkg::MODE_INSERT, 16'h0000, 8'd59, 1'b1);
        add_request(fcpq_pkg::MODE_INSERT, 16'hFFFF, 8'd255, 1'b1);
        for (n = 0; n < 5; n++)
            add_request(fcpq_pkg::MODE_REMOVE, 16'hFFFF, 8'hFF, 1'b1);
        // fill one class past its depth so the last insert is dropped
        for (n = 0; n <= DEPTH; n++)
            add_request(fcpq_pkg::MODE_INSERT, TAG_W'(n * 16'h1111), 8'd0, 1'b1);
        wait_drained();

        phase_age[0] = 8'd0;
        phase_age[1] = 8'd255;
        phase_age[2] = 8'd60;
        phase_age[3] = AGE_W'($urandom_range(0, 255));
        phase_age[4] = 8'd1;
        phase_age[5] = 8'd254;
        phase_age[6] = AGE_W'($urandom_range(0, 255));
        phase_age[7] = AGE_W'($urandom_range(0, 255));
        phase_age[8] = 8'd59;

        bias = 50;
        for (p = 0; p < PHASES; p++)
        begin
            write_senior_age(phase_age[p]);
            @(posedge clk);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       bias = 15;
                        1:       bias = 50;
                        default: bias = 85;
                    endcase
                end
                if ($urandom_range(0, 99) < bias)
                    m = fcpq_pkg::MODE_INSERT;
                else
                    m = fcpq_pkg::MODE_REMOVE;
                add_request(m, TAG_W'($urandom), pick_age(), 1'($urandom));
            end
            if (p == 2)
            begin
                @(negedge clk);
                rsp_hold_left <= HOLD_CYCLES;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fcpq_pkg.sv
hw/rtl/fcpq_if.sv
hw/rtl/four_class_priority_queue_core.sv
hw/rtl/fcpq_checker.sv
tb/sv/testbench.sv
